// File: rtl/crfp_pkg.sv
// ----------------------------------------------------------------------------
// Cabinet reply frame parser package
// Shared types and constants: frame headers, status codes, register indexes
// and the configuration and result structures.
// ----------------------------------------------------------------------------
package crfp_pkg;

    localparam logic [31:0] HDR_A = 32'h1B46_4441;
    localparam logic [31:0] HDR_B = 32'h1D48_4643;

    localparam logic [3:0] ST_DOOR_CLOSED   = 4'd0;
    localparam logic [3:0] ST_DOOR_OPEN     = 4'd1;
    localparam logic [3:0] ST_DRAWER_CLOSED = 4'd2;
    localparam logic [3:0] ST_DRAWER_OPEN   = 4'd3;
    localparam logic [3:0] ST_SENSORS       = 4'd4;
    localparam logic [3:0] ST_LOCK_ACK      = 4'd5;
    localparam logic [3:0] ST_LED_ACK       = 4'd6;
    localparam logic [3:0] ST_FRAME_ERR     = 4'd7;
    localparam logic [3:0] ST_HSUM_ERR      = 4'd8;
    localparam logic [3:0] ST_UNKNOWN_CMD   = 4'd9;

    localparam logic [2:0] CFG_DOOR   = 3'd0;
    localparam logic [2:0] CFG_DRAWER = 3'd1;
    localparam logic [2:0] CFG_SENSOR = 3'd2;
    localparam logic [2:0] CFG_LOCK   = 3'd3;
    localparam logic [2:0] CFG_LED    = 3'd4;

    typedef struct packed {
        logic [7:0] door_code;
        logic [7:0] drawer_code;
        logic [7:0] sensor_code;
        logic [7:0] lock_code;
        logic [7:0] led_code;
    } t_cfg;

    typedef struct packed {
        logic [3:0] status;
        logic [7:0] command_code;
        logic [7:0] sensor_bits;
    } t_result;

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_BODY = 4'b0010,
        PH_HSUM = 4'b0100,
        PH_EXT  = 4'b1000
    } t_phase;

endpackage

// File: rtl/cabinet_reply_frame_parser_unit.sv
// Flow: a byte is registered on acceptance, processed by the parser stage, and
//   its status (if any) is held in the result register until the receiver takes it.
// Throughput: one byte per cycle while the result is not stalled, set by the
//   single parser stage between the input register and the result register.
// Reset: synchronous, active low; clears the frame state, empties both
//   registers and restores the default command codes. No clearing pass.
// ----------------------------------------------------------------------------
// Cabinet reply frame parser
// Byte-stream parser for cabinet reply frames with an input register, the
// frame state machine and a result register.
// ----------------------------------------------------------------------------
module cabinet_reply_frame_parser_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [3:0] o_status,
    output logic [7:0] o_command_code,
    output logic [7:0] o_sensor_bits,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import crfp_pkg::*;

    logic    r_in_valid;
    logic    [7:0] r_in_byte;
    logic    r_out_valid;
    t_result r_out;

    logic    pipe_move;
    logic    proc_fire;
    logic    core_emit;
    t_result core_result;
    t_cfg    cfg;

    // The parser stage advances whenever the result register is free or
    // being emptied in this cycle.
    assign pipe_move = !r_out_valid || !i_stall;
    assign proc_fire = r_in_valid && pipe_move;
    assign o_stall   = r_in_valid && !pipe_move;

    crfp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    crfp_parse_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (proc_fire),
        .i_byte   (r_in_byte),
        .i_cfg    (cfg),
        .o_emit   (core_emit),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pipe_move) begin
            r_out_valid <= proc_fire && core_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_move && proc_fire && core_emit) begin
            r_out <= core_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out.status;
    assign o_command_code = r_out.command_code;
    assign o_sensor_bits  = r_out.sensor_bits;

`ifndef ASSERT_OFF
    a_no_emit_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pipe_move && !(proc_fire && core_emit) |=> !o_valid)
        else $error("result presented without an emitting byte");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= ST_UNKNOWN_CMD)
        else $error("status code out of range");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && o_valid && i_stall)
        else $error("input stalled without a blocked result");
`endif

endmodule

// File: rtl/crfp_cfg_regs.sv
// ----------------------------------------------------------------------------
// Command code registers
// Holds the five programmable command codes; writes beyond the list are
// dropped.
// ----------------------------------------------------------------------------
module crfp_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    input  logic [2:0]      i_cfg_index,
    input  logic [7:0]      i_cfg_data,
    output logic            o_cfg_ready,
    output crfp_pkg::t_cfg  o_cfg
);
    import crfp_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DOOR:   n_cfg.door_code   = i_cfg_data;
                CFG_DRAWER: n_cfg.drawer_code = i_cfg_data;
                CFG_SENSOR: n_cfg.sensor_code = i_cfg_data;
                CFG_LOCK:   n_cfg.lock_code   = i_cfg_data;
                CFG_LED:    n_cfg.led_code    = i_cfg_data;
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.door_code   <= 8'd64;
            r_cfg.drawer_code <= 8'd65;
            r_cfg.sensor_code <= 8'd66;
            r_cfg.lock_code   <= 8'd17;
            r_cfg.led_code    <= 8'd18;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// File: rtl/crfp_parse_core.sv
// ----------------------------------------------------------------------------
// Frame parser core
// Per-byte frame state machine: header hunt, body, header checksum and
// extension, producing at most one status per byte.
// ----------------------------------------------------------------------------
module crfp_parse_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [7:0]         i_byte,
    input  crfp_pkg::t_cfg     i_cfg,
    output logic               o_emit,
    output crfp_pkg::t_result  o_result
);
    import crfp_pkg::*;

    t_phase      r_phase,  n_phase;
    logic [23:0] r_window, n_window;
    logic [7:0]  r_pos,    n_pos;
    logic [7:0]  r_cmd,    n_cmd;
    logic [7:0]  r_len,    n_len;
    logic [7:0]  r_sum,    n_sum;
    logic [7:0]  r_first,  n_first;

    logic [31:0] hunt_word;
    logic [7:0]  data_byte;
    logic        ext_last;
    logic [7:0]  sum_next;

    assign hunt_word = {r_window, i_byte};
    assign data_byte = (r_pos == 8'd0) ? i_byte : r_first;
    assign ext_last  = ({1'b0, r_pos} + 9'd1) >= {1'b0, r_len};
    assign sum_next  = r_sum + i_byte;

    always_comb begin
        n_phase  = r_phase;
        n_window = r_window;
        n_pos    = r_pos;
        n_cmd    = r_cmd;
        n_len    = r_len;
        n_sum    = r_sum;
        n_first  = r_first;
        o_emit   = 1'b0;
        o_result.status       = ST_FRAME_ERR;
        o_result.command_code = r_cmd;
        o_result.sensor_bits  = 8'd0;

        case (r_phase)
            PH_HUNT: begin
                if (hunt_word == HDR_A || hunt_word == HDR_B) begin
                    n_phase  = PH_BODY;
                    n_window = 24'd0;
                    n_pos    = 8'd0;
                    n_sum    = 8'd0;
                end else begin
                    n_window = hunt_word[23:0];
                end
            end
            PH_BODY: begin
                n_sum = sum_next;
                if (r_pos == 8'd1) begin
                    n_cmd = i_byte;
                end else if (r_pos == 8'd2) begin
                    n_len = i_byte;
                end
                if (r_pos >= 8'd3) begin
                    n_phase = PH_HSUM;
                    n_pos   = 8'd0;
                end else begin
                    n_pos = r_pos + 8'd1;
                end
            end
            PH_HSUM: begin
                if (i_byte != r_sum) begin
                    o_emit          = 1'b1;
                    o_result.status = ST_HSUM_ERR;
                end else if (r_len == 8'd0) begin
                    o_emit = 1'b1;
                    if (r_cmd == i_cfg.lock_code) begin
                        o_result.status = ST_LOCK_ACK;
                    end else if (r_cmd == i_cfg.led_code) begin
                        o_result.status = ST_LED_ACK;
                    end else begin
                        o_result.status = ST_FRAME_ERR;
                    end
                end else begin
                    n_phase = PH_EXT;
                    n_pos   = 8'd0;
                    n_sum   = 8'd0;
                    n_first = 8'd0;
                end
            end
            PH_EXT: begin
                if (r_pos == 8'd0) begin
                    n_first = i_byte;
                end
                if (ext_last) begin
                    o_emit               = 1'b1;
                    o_result.sensor_bits = data_byte;
                    if (i_byte != r_sum) begin
                        o_result.status = ST_FRAME_ERR;
                    end else if (r_cmd == i_cfg.door_code) begin
                        o_result.status = (data_byte == 8'd0) ? ST_DOOR_CLOSED
                                                              : ST_DOOR_OPEN;
                    end else if (r_cmd == i_cfg.drawer_code) begin
                        o_result.status = (data_byte == 8'd0) ? ST_DRAWER_CLOSED
                                                              : ST_DRAWER_OPEN;
                    end else if (r_cmd == i_cfg.sensor_code) begin
                        o_result.status = ST_SENSORS;
                    end else begin
                        o_result.status = ST_UNKNOWN_CMD;
                    end
                end else begin
                    n_sum = sum_next;
                    n_pos = r_pos + 8'd1;
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase

        // A finished frame always drops back to the header hunt.
        if (o_emit) begin
            n_phase  = PH_HUNT;
            n_window = 24'd0;
            n_pos    = 8'd0;
            n_sum    = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_window <= 24'd0;
            r_pos    <= 8'd0;
            r_cmd    <= 8'd0;
            r_len    <= 8'd0;
            r_sum    <= 8'd0;
            r_first  <= 8'd0;
        end else if (i_en) begin
            r_phase  <= n_phase;
            r_window <= n_window;
            r_pos    <= n_pos;
            r_cmd    <= n_cmd;
            r_len    <= n_len;
            r_sum    <= n_sum;
            r_first  <= n_first;
        end
    end

endmodule

// File: sim/crfp_status_checker.sv
// ----------------------------------------------------------------------------
// Cabinet reply frame parser status checker
// Watches the byte, configuration and status channels of the parser. It keeps
// its own copy of the command codes and the frame state, works out the status
// that each accepted byte finishes, and compares every accepted status with
// the oldest one outstanding.
// ----------------------------------------------------------------------------
module crfp_status_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [3:0]  i_status,
    input  logic [7:0]  i_command_code,
    input  logic [7:0]  i_sensor_bits,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output int unsigned o_mismatches,
    output int unsigned o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import crfp_pkg::*;

    localparam t_cfg DEFAULT_CODES = '{door_code: 8'd64, drawer_code: 8'd65,
                                       sensor_code: 8'd66, lock_code: 8'd17,
                                       led_code: 8'd18};

    t_cfg        codes;
    logic [23:0] hunt_window;
    t_phase      frame_phase;
    logic [7:0]  byte_pos;
    logic [7:0]  saved_cmd;
    logic [7:0]  ext_len;
    logic [7:0]  check_sum;
    logic [7:0]  first_ext_byte;
    t_result     pending_statuses[$];
    t_result     oldest;
    int unsigned mismatch_count = 0;

    function automatic void restart_hunt();
        frame_phase = PH_HUNT;
        hunt_window = '0;
        byte_pos    = '0;
        check_sum   = '0;
    endfunction

    function automatic void post_status(input logic [3:0] st, input logic [7:0] data);
        pending_statuses.push_back('{status: st, command_code: saved_cmd, sensor_bits: data});
        restart_hunt();
    endfunction

    // Door beats drawer beats sensor when registers hold the same code.
    function automatic logic [3:0] extension_status();
        if (saved_cmd == codes.door_code)
            return (first_ext_byte == 8'h00) ? ST_DOOR_CLOSED : ST_DOOR_OPEN;
        if (saved_cmd == codes.drawer_code)
            return (first_ext_byte == 8'h00) ? ST_DRAWER_CLOSED : ST_DRAWER_OPEN;
        if (saved_cmd == codes.sensor_code)
            return ST_SENSORS;
        return ST_UNKNOWN_CMD;
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        logic [31:0] window;
        window = {hunt_window, b};
        case (frame_phase)
            PH_HUNT: begin
                if (window == HDR_A || window == HDR_B) begin
                    restart_hunt();
                    frame_phase = PH_BODY;
                end else begin
                    hunt_window = window[23:0];
                end
            end
            PH_BODY: begin
                check_sum = check_sum + b;
                if (byte_pos == 8'd1)
                    saved_cmd = b;
                else if (byte_pos == 8'd2)
                    ext_len = b;
                if (byte_pos >= 8'd3) begin
                    frame_phase = PH_HSUM;
                    byte_pos    = '0;
                end else begin
                    byte_pos = byte_pos + 8'd1;
                end
            end
            PH_HSUM: begin
                if (b != check_sum) begin
                    post_status(ST_HSUM_ERR, 8'h00);
                end else if (ext_len == 8'd0) begin
                    if (saved_cmd == codes.lock_code)
                        post_status(ST_LOCK_ACK, 8'h00);
                    else if (saved_cmd == codes.led_code)
                        post_status(ST_LED_ACK, 8'h00);
                    else
                        post_status(ST_FRAME_ERR, 8'h00);
                end else begin
                    frame_phase    = PH_EXT;
                    byte_pos       = '0;
                    check_sum      = '0;
                    first_ext_byte = '0;
                end
            end
            PH_EXT: begin
                if (byte_pos == 8'd0)
                    first_ext_byte = b;
                // The last extension byte carries the sum of the ones before it.
                if ({1'b0, byte_pos} + 9'd1 >= {1'b0, ext_len}) begin
                    if (b != check_sum)
                        post_status(ST_FRAME_ERR, first_ext_byte);
                    else
                        post_status(extension_status(), first_ext_byte);
                end else begin
                    check_sum = check_sum + b;
                    byte_pos  = byte_pos + 8'd1;
                end
            end
            default: begin
                restart_hunt();
            end
        endcase
    endfunction

    task automatic compare_field(input string field, input logic [7:0] expected,
                                 input logic [7:0] actual);
        if (actual !== expected) begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected %02h, got %02h",
                     $time, field, expected, actual);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            codes          = DEFAULT_CODES;
            saved_cmd      = '0;
            ext_len        = '0;
            first_ext_byte = '0;
            restart_hunt();
            pending_statuses.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_statuses.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: status %0d (command %02h, sensors %02h) with none expected",
                             $time, i_status, i_command_code, i_sensor_bits);
                end else begin
                    oldest = pending_statuses.pop_front();
                    compare_field("status", {4'h0, oldest.status}, {4'h0, i_status});
                    compare_field("command_code", oldest.command_code, i_command_code);
                    compare_field("sensor_bits", oldest.sensor_bits, i_sensor_bits);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DOOR:   codes.door_code   = i_cfg_data;
                    CFG_DRAWER: codes.drawer_code = i_cfg_data;
                    CFG_SENSOR: codes.sensor_code = i_cfg_data;
                    CFG_LOCK:   codes.lock_code   = i_cfg_data;
                    CFG_LED:    codes.led_code    = i_cfg_data;
                    default:    ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                parse_byte(i_rx_byte);
        end
        o_pending    <= pending_statuses.size();
        o_mismatches <= mismatch_count;
    end

endmodule

// File: sim/tb_cabinet_reply_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// Cabinet reply frame parser testbench
// Sends directed and random reply frames, line noise and cut-off frames to
// the parser under several command code settings, with bursty byte delivery
// and a stalling status receiver. The status checker does the comparison.
// ----------------------------------------------------------------------------
module tb_cabinet_reply_frame_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import crfp_pkg::*;

    localparam int          ITEM_TARGET  = 1050;
    localparam int          PHASE_BYTES  = 130;
    localparam int          DRAIN_CYCLES = 4;
    localparam longint      CYCLE_LIMIT  = 400000;
    localparam int          STALL_NONE   = 0;
    localparam int          STALL_RANDOM = 1;
    localparam int          STALL_RUNS   = 2;
    localparam t_cfg        DEFAULT_CODES = '{door_code: 8'd64, drawer_code: 8'd65,
                                              sensor_code: 8'd66, lock_code: 8'd17,
                                              led_code: 8'd18};

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_rx_byte   = 8'h00;
    logic        i_stall     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_index = CFG_DOOR;
    logic [7:0]  i_cfg_data  = 8'h00;
    logic        o_stall;
    logic        o_valid;
    logic [3:0]  o_status;
    logic [7:0]  o_command_code;
    logic [7:0]  o_sensor_bits;
    logic        o_cfg_ready;
    int unsigned mismatches;
    int unsigned pending;

    t_cfg        cur_codes = DEFAULT_CODES;
    int          burst_left = 0;
    int          frame_bytes = 0;
    longint      cycle_count = 0;
    int          stall_mode = STALL_NONE;
    int          mode_left = 0;
    int          run_left = 0;
    logic        run_hold = 1'b0;

    cabinet_reply_frame_parser_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_command_code (o_command_code),
        .o_sensor_bits  (o_sensor_bits),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    crfp_status_checker checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_rx_byte      (i_rx_byte),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_status       (o_status),
        .i_command_code (o_command_code),
        .i_sensor_bits  (o_sensor_bits),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out with %0d statuses outstanding", pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Status receiver: alternates between no stalls, coin-flip stalls and
    // runs of stalls of random length.
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(STALL_NONE, STALL_RUNS);
            mode_left  = $urandom_range(40, 300);
        end
        mode_left--;
        case (stall_mode)
            STALL_NONE:   i_stall <= 1'b0;
            STALL_RANDOM: i_stall <= 1'($urandom_range(0, 1));
            default: begin
                if (run_left == 0) begin
                    run_hold = ~run_hold;
                    run_left = $urandom_range(1, 8);
                end
                run_left--;
                i_stall <= run_hold;
            end
        endcase
    end

    // Bytes go out in bursts; a new burst is usually preceded by a gap.
    task automatic send_byte(input logic [7:0] b);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                      : $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        frame_bytes++;
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_codes();
        write_reg(CFG_DOOR,   cur_codes.door_code);
        write_reg(CFG_DRAWER, cur_codes.drawer_code);
        write_reg(CFG_SENSOR, cur_codes.sensor_code);
        write_reg(CFG_LOCK,   cur_codes.lock_code);
        write_reg(CFG_LED,    cur_codes.led_code);
        // Indexes past the last register must be ignored.
        write_reg(CFG_LED + 3'($urandom_range(1, 3)), 8'($urandom));
    endtask

    task automatic send_frame(input bit alt_hdr, input logic [7:0] command,
                              input logic [7:0] len, input logic [7:0] first_ext,
                              input bit bad_hsum, input bit bad_esum);
        logic [31:0] hdr;
        logic [7:0]  body [4];
        logic [7:0]  total;
        logic [7:0]  b;
        int          i;
        hdr     = alt_hdr ? HDR_B : HDR_A;
        body[0] = 8'($urandom);
        body[1] = command;
        body[2] = len;
        body[3] = 8'($urandom);
        total   = 8'h00;
        for (i = 3; i >= 0; i--)
            send_byte(hdr[8*i +: 8]);
        for (i = 0; i < 4; i++) begin
            send_byte(body[i]);
            total = total + body[i];
        end
        send_byte(bad_hsum ? total ^ 8'($urandom_range(1, 255)) : total);
        if (len != 8'd0) begin
            total = 8'h00;
            for (i = 0; i < int'(len) - 1; i++) begin
                b = (i == 0) ? first_ext : 8'($urandom);
                send_byte(b);
                total = total + b;
            end
            send_byte(bad_esum ? total ^ 8'($urandom_range(1, 255)) : total);
        end
    endtask

    function automatic logic [7:0] pick_command();
        case ($urandom_range(0, 7))
            0:       return cur_codes.door_code;
            1:       return cur_codes.drawer_code;
            2:       return cur_codes.sensor_code;
            3:       return cur_codes.lock_code;
            4:       return cur_codes.led_code;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_random_traffic();
        int          kind;
        int          k;
        int          i;
        logic [7:0]  len;
        logic [31:0] hdr;
        kind = $urandom_range(0, 99);
        hdr  = ($urandom_range(0, 1) != 0) ? HDR_B : HDR_A;
        if (kind < 80) begin
            k = $urandom_range(0, 99);
            if (k < 25)
                len = 8'd0;
            else if (k < 35)
                len = 8'd1;
            else if (k < 88)
                len = 8'($urandom_range(2, 8));
            else if (k < 99)
                len = 8'($urandom_range(9, 40));
            else
                len = 8'($urandom_range(200, 255));
            send_frame(1'($urandom_range(0, 1)), pick_command(), len,
                       ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom),
                       $urandom_range(0, 11) == 0, $urandom_range(0, 11) == 0);
        end else if (kind < 90) begin
            // Line noise, sometimes starting with a header that is cut short.
            if ($urandom_range(0, 1) != 0) begin
                k = $urandom_range(1, 3);
                for (i = 3; i > 3 - k; i--)
                    send_byte(hdr[8*i +: 8]);
            end
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end else begin
            // A frame that breaks off; what follows is taken as its remainder.
            for (i = 3; i >= 0; i--)
                send_byte(hdr[8*i +: 8]);
            k = $urandom_range(1, 6);
            repeat (k) send_byte(8'($urandom));
        end
    endtask

    initial begin
        int ph;
        int phase_end;
        logic [7:0] shared;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames under the default command codes.
        send_byte(HDR_A[31:24]);
        send_frame(1'b0, cur_codes.lock_code,   8'd0, 8'h00, 1'b0, 1'b0);
        send_frame(1'b1, cur_codes.led_code,    8'd0, 8'h00, 1'b0, 1'b0);
        send_frame(1'b0, 8'h00,                 8'd0, 8'h00, 1'b0, 1'b0);
        send_frame(1'b0, cur_codes.door_code,   8'd2, 8'h00, 1'b0, 1'b0);
        send_frame(1'b1, cur_codes.door_code,   8'd3, 8'hFF, 1'b0, 1'b0);
        send_frame(1'b0, cur_codes.drawer_code, 8'd2, 8'h00, 1'b0, 1'b0);
        send_frame(1'b0, cur_codes.drawer_code, 8'd2, 8'h80, 1'b0, 1'b0);
        send_frame(1'b1, cur_codes.sensor_code, 8'd4, 8'hA5, 1'b0, 1'b0);
        send_frame(1'b0, 8'hFF,                 8'd2, 8'h3C, 1'b0, 1'b0);
        send_frame(1'b0, cur_codes.sensor_code, 8'd3, 8'h01, 1'b0, 1'b1);
        send_frame(1'b0, cur_codes.door_code,   8'd0, 8'h00, 1'b1, 1'b0);
        send_frame(1'b1, cur_codes.door_code,   8'd1, 8'h00, 1'b0, 1'b0);
        send_frame(1'b0, cur_codes.drawer_code, 8'd1, 8'h00, 1'b0, 1'b1);
        // A second header straight after the first is read as body bytes.
        send_byte(HDR_A[31:24]);
        send_byte(HDR_A[23:16]);
        send_byte(HDR_A[15:8]);
        send_byte(HDR_A[7:0]);
        send_byte(HDR_B[31:24]);
        send_byte(HDR_B[23:16]);
        send_byte(HDR_B[15:8]);
        send_byte(HDR_B[7:0]);
        send_byte(8'h00);

        for (ph = 0; frame_bytes < ITEM_TARGET; ph++) begin
            settle();
            case (ph % 6)
                0: cur_codes = '{default: 8'h00};
                1: cur_codes = '{default: 8'hFF};
                2: begin
                    shared                = 8'($urandom);
                    cur_codes.door_code   = shared;
                    cur_codes.drawer_code = shared;
                    cur_codes.sensor_code = shared;
                    shared                = 8'($urandom);
                    cur_codes.lock_code   = shared;
                    cur_codes.led_code    = shared;
                end
                3: cur_codes = DEFAULT_CODES;
                default: begin
                    cur_codes.door_code   = 8'($urandom);
                    cur_codes.drawer_code = 8'($urandom);
                    cur_codes.sensor_code = 8'($urandom);
                    cur_codes.lock_code   = 8'($urandom);
                    cur_codes.led_code    = 8'($urandom);
                end
            endcase
            program_codes();
            phase_end = frame_bytes + PHASE_BYTES;
            while (frame_bytes < phase_end && frame_bytes < ITEM_TARGET)
                send_random_traffic();
        end

        settle();
        if (pending != 0)
            $display("%0d statuses never arrived", pending);
        if (mismatches == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
